FILE: rtl/spm_pkg.sv
// Shared constants, types and helpers of the sprite over playfield priority mixer.
package spm_pkg;

  localparam int PRIO_SHIFT = 12;
  localparam int WORD_W     = 16;
  localparam int TAG_W      = 8;
  localparam int PRIO_W     = WORD_W - PRIO_SHIFT;
  localparam int DEPTH_W    = 8;

  localparam logic [WORD_W-1:0] SPRITE_FLAG = 16'h1000;
  localparam logic [WORD_W-1:0] STAIN_FLAG  = 16'h2000;
  localparam logic [TAG_W-1:0]  FG_LAYER    = 8'h80;
  localparam logic [WORD_W-1:0] MARK_LOW    = 16'h003f;

  localparam logic [WORD_W-1:0] COLOR_MASK = WORD_W'((32'd1 << PRIO_SHIFT) - 32'd1);
  localparam logic [WORD_W-1:0] MARK_BASE  = WORD_W'(32'd4 << PRIO_SHIFT);
  localparam logic [WORD_W-1:0] MARK_MASK  = MARK_BASE | MARK_LOW;
  localparam logic [WORD_W-1:0] START_MARK = MARK_BASE | 16'h0003;
  localparam logic [WORD_W-1:0] END_MARK   = MARK_BASE | 16'h0007;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 8'sd127;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -8'sd128;

  typedef struct packed {
    logic [WORD_W-1:0] sprite_word;
    logic [WORD_W-1:0] playfield_word;
    logic [TAG_W-1:0]  priority_tag;
    logic              line_start;
  } pix_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]         pixel_out;
    logic signed [DEPTH_W-1:0] depth_next;
  } merge_res_t;

endpackage

FILE: rtl/spm_in_if.sv
// Input channel: one pixel request with its sprite, playfield and tag words.
interface spm_in_if;
  logic                          valid;
  logic                          ready;
  logic [spm_pkg::WORD_W-1:0]    sprite_word;
  logic [spm_pkg::WORD_W-1:0]    playfield_word;
  logic [spm_pkg::TAG_W-1:0]     priority_tag;
  logic                          line_start;

  modport source (output valid, sprite_word, playfield_word, priority_tag, line_start,
                  input ready);
  modport sink (input valid, sprite_word, playfield_word, priority_tag, line_start,
                output ready);
endinterface

FILE: rtl/spm_out_if.sv
// Output channel: one merged pixel per request.
interface spm_out_if;
  logic                       valid;
  logic                       ready;
  logic [spm_pkg::WORD_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

FILE: rtl/spm_merge.sv
// Combinational priority merge, stain marking and nesting counter update for one pixel.
module spm_merge (
  input  spm_pkg::pix_req_t                  req,
  input  logic signed [spm_pkg::DEPTH_W-1:0] depth,
  output spm_pkg::merge_res_t                res
);

  logic [spm_pkg::PRIO_W-1:0]         prio;
  logic                               hidden;
  logic                               draw;
  logic [spm_pkg::WORD_W-1:0]         merged;
  logic [spm_pkg::WORD_W-1:0]         mark_bits;
  logic signed [spm_pkg::DEPTH_W-1:0] depth_cur;
  logic signed [spm_pkg::DEPTH_W-1:0] depth_mid;

  always_comb begin
    prio   = req.sprite_word[spm_pkg::WORD_W-1:spm_pkg::PRIO_SHIFT];
    hidden = prio[2] && (prio[1:0] != 2'b00);
    if ((req.priority_tag & spm_pkg::FG_LAYER) != '0) begin
      draw = prio > spm_pkg::PRIO_W'(req.priority_tag[3:2]);
    end else begin
      draw = req.priority_tag[1:0] != 2'b11;
    end
    if ((req.sprite_word != '0) && !hidden && draw) begin
      merged = (req.sprite_word & spm_pkg::COLOR_MASK) | spm_pkg::SPRITE_FLAG;
    end else begin
      merged = req.playfield_word;
    end

    // A start marker counts before the stain test, an end marker after it.
    mark_bits = req.sprite_word & spm_pkg::MARK_MASK;
    depth_cur = req.line_start ? '0 : depth;
    depth_mid = depth_cur;
    if ((mark_bits == spm_pkg::START_MARK) && (depth_cur != spm_pkg::DEPTH_MAX)) begin
      depth_mid = depth_cur + 8'sd1;
    end
    if ((depth_mid != '0) && ((merged & spm_pkg::SPRITE_FLAG) == '0)) begin
      merged = merged | spm_pkg::STAIN_FLAG;
    end
    res.depth_next = depth_mid;
    if ((mark_bits == spm_pkg::END_MARK) && (depth_mid != spm_pkg::DEPTH_MIN)) begin
      res.depth_next = depth_mid - 8'sd1;
    end
    res.pixel_out = merged;
  end

endmodule

FILE: rtl/sprite_playfield_priority_mixer_top.sv
// Top level of the sprite over playfield priority mixer.
//
// Usage: pixels enter on pix_in in raster order, each request carrying the
// sprite word, the playfield word already drawn there, the playfield
// priority tag and a line_start flag on the first pixel of each scanline.
// One merged pixel leaves on pix_out for every request, in the same order.
// Both channels use valid/ready; a request moves when both are high.
//
// A request is held in an input register, merged by one level of logic, and
// placed in the output register. Throughput is one pixel per clock while the
// receiver does not stall; the only state carried from one pixel to the next
// is the 8-bit signed nesting counter, updated in the merge stage.
//
// When the receiver stalls, both registers fill and pix_in.ready falls; no
// request is lost or repeated. Synchronous reset empties both registers and
// clears the nesting counter. Each line_start also clears the counter before
// its own pixel is handled.
module sprite_playfield_priority_mixer_top (
  input  logic       clk,
  input  logic       rst,
  spm_in_if.sink     pix_in,
  spm_out_if.source  pix_out
);

  spm_pkg::pix_req_t                  req_reg;
  logic                               req_valid;
  logic signed [spm_pkg::DEPTH_W-1:0] depth;
  logic [spm_pkg::WORD_W-1:0]         pixel_reg;
  logic                               pixel_valid;
  spm_pkg::merge_res_t                res;
  logic                               out_load;
  logic                               req_load;

  assign out_load = !pixel_valid || pix_out.ready;
  assign req_load = !req_valid || out_load;
  assign pix_in.ready = req_load;

  spm_merge u_merge (
    .req   (req_reg),
    .depth (depth),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid   <= 1'b0;
      pixel_valid <= 1'b0;
      depth       <= '0;
    end else begin
      if (req_load) begin
        req_valid <= pix_in.valid;
      end
      if (out_load) begin
        pixel_valid <= req_valid;
        if (req_valid) begin
          depth <= res.depth_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_load && pix_in.valid) begin
      req_reg.sprite_word    <= pix_in.sprite_word;
      req_reg.playfield_word <= pix_in.playfield_word;
      req_reg.priority_tag   <= pix_in.priority_tag;
      req_reg.line_start     <= pix_in.line_start;
    end
    if (out_load && req_valid) begin
      pixel_reg <= res.pixel_out;
    end
  end

  assign pix_out.valid     = pixel_valid;
  assign pix_out.pixel_out = pixel_reg;

endmodule
